### src/ncf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncf_pkg
// Shared types and constants of the negative cycle finder.
// ----------------------------------------------------------------------------
package ncf_pkg;

	localparam int VTX_W  = 5;
	localparam int VX_W   = 6;
	localparam int DIST_W = 32;
	localparam int IN_W_W = 16;

	localparam logic [VX_W-1:0] PRED_NONE = 6'd63;

	typedef struct packed {
		logic [VTX_W-1:0]         src;
		logic [VTX_W-1:0]         dst;
		logic signed [DIST_W-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic                     we;
		logic [VX_W-1:0]          addr;
		logic [VX_W-1:0]          pred;
		logic signed [DIST_W-1:0] dval;
	} dist_wr_t;

	typedef struct packed {
		logic [VX_W-1:0]          pred;
		logic signed [DIST_W-1:0] dval;
	} dist_rd_t;

endpackage

### src/ncf_edge_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncf_edge_store
// Edge memory with fill count; one write per accepted request while not full, registered read.
// ----------------------------------------------------------------------------
module ncf_edge_store #(
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16,
	parameter int EAW         = 8,
	parameter int ECW         = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ncf_pkg::VTX_W-1:0]     wr_src,
	input  logic [ncf_pkg::VTX_W-1:0]     wr_dst,
	input  logic [ncf_pkg::IN_W_W-1:0]    wr_weight,
	input  logic                          clear,
	input  logic [EAW-1:0]                raddr,
	output logic [ECW-1:0]                total,
	output ncf_pkg::edge_t                rdata
);
	import ncf_pkg::*;

	localparam int EW = 2 * VTX_W + WEIGHT_BITS;

	logic [EW-1:0]          mem [MAX_EDGES];
	logic [EW-1:0]          rd_q;
	logic [ECW-1:0]         total_q;
	logic [DIST_W-1:0]      w_ext;
	logic [WEIGHT_BITS-1:0] rd_w;
	logic                   do_wr;

	assign w_ext = DIST_W'(wr_weight);
	assign do_wr = wr_en && (total_q < ECW'(MAX_EDGES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (clear) begin
			total_q <= '0;
		end else if (do_wr) begin
			total_q <= total_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[total_q[EAW-1:0]] <= {wr_src, wr_dst, w_ext[WEIGHT_BITS-1:0]};
		end
		rd_q <= mem[raddr];
	end

	assign rd_w         = rd_q[WEIGHT_BITS-1:0];
	assign rdata.src    = rd_q[EW-1 -: VTX_W];
	assign rdata.dst    = rd_q[EW-VTX_W-1 -: VTX_W];
	assign rdata.weight = DIST_W'(signed'(rd_w));
	assign total        = total_q;

endmodule

### src/ncf_dist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncf_dist_ram
// Distance and predecessor memory; one write port, two registered reads.
// ----------------------------------------------------------------------------
module ncf_dist_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  ncf_pkg::dist_wr_t         wr,
	input  logic [ncf_pkg::VX_W-1:0]  raddr_a,
	input  logic [ncf_pkg::VX_W-1:0]  raddr_b,
	output ncf_pkg::dist_rd_t         rdata_a,
	output ncf_pkg::dist_rd_t         rdata_b
);
	import ncf_pkg::*;

	dist_rd_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr[AW-1:0]] <= '{pred: wr.pred, dval: wr.dval};
		end
		rdata_a <= mem[raddr_a[AW-1:0]];
		rdata_b <= mem[raddr_b[AW-1:0]];
	end

endmodule

### src/ncf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncf_engine
// Search sequencer: relaxation rounds, check round, cycle walk and output.
// ----------------------------------------------------------------------------
module ncf_engine #(
	parameter int MAX_VERTICES = 32,
	parameter int VIW          = 5,
	parameter int EAW          = 8,
	parameter int ECW          = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [ncf_pkg::VX_W-1:0]      n,
	input  logic [ECW-1:0]                total,
	output logic [EAW-1:0]                edge_raddr,
	input  ncf_pkg::edge_t                edge_rd,
	output ncf_pkg::dist_wr_t             dw,
	output logic [ncf_pkg::VX_W-1:0]      raddr_a,
	output logic [ncf_pkg::VX_W-1:0]      raddr_b,
	input  ncf_pkg::dist_rd_t             rd_a,
	input  ncf_pkg::dist_rd_t             rd_b,
	output logic                          busy,
	output logic                          clear_edges,
	output logic                          strobe,
	output logic                          found,
	output logic [ncf_pkg::VTX_W-1:0]     vertex,
	output logic                          last
);
	import ncf_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_NEXTSRC = 4'd1;
	localparam logic [3:0] S_EREAD   = 4'd2;
	localparam logic [3:0] S_DREAD   = 4'd3;
	localparam logic [3:0] S_RELAX   = 4'd4;
	localparam logic [3:0] S_WREAD   = 4'd5;
	localparam logic [3:0] S_WSTEP   = 4'd6;
	localparam logic [3:0] S_CREAD   = 4'd7;
	localparam logic [3:0] S_CSTEP   = 4'd8;
	localparam logic [3:0] S_OHEAD   = 4'd9;
	localparam logic [3:0] S_ORD     = 4'd10;
	localparam logic [3:0] S_OWR     = 4'd11;

	logic [3:0]              state_q;
	logic [VX_W-1:0]         s_q, round_q, x_q, walk_q, cur_q, cnt_q, idx_q;
	logic [ECW-1:0]          j_q;
	edge_t                   e_q;
	logic [MAX_VERTICES-1:0] valid_q, reached_q;
	logic [VX_W-1:0]         chain [MAX_VERTICES];
	logic [VX_W-1:0]         chain_rd_q;
	logic                    strobe_q, found_q, last_q;
	logic [VTX_W-1:0]        vertex_q;

	logic [VX_W-1:0]         u, v, p, paddr;
	logic                    inr, ok, better, fin;
	logic signed [DIST_W:0]  sum33;
	logic signed [DIST_W-1:0] sum;

	function automatic logic [VIW-1:0] vi(input logic [VX_W-1:0] a);
		return a[VIW-1:0];
	endfunction

	assign u      = VX_W'(e_q.src);
	assign v      = VX_W'(e_q.dst);
	assign inr    = (u < n) && (v < n);
	assign sum33  = {rd_a.dval[DIST_W-1], rd_a.dval} + {e_q.weight[DIST_W-1], e_q.weight};
	always_comb begin
		if (sum33[DIST_W] != sum33[DIST_W-1]) begin
			sum = sum33[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
		end else begin
			sum = sum33[DIST_W-1:0];
		end
	end
	assign better = !valid_q[vi(v)] || (sum < rd_b.dval);
	assign ok     = inr && valid_q[vi(u)] && better;

	assign paddr = (state_q == S_WSTEP) ? x_q : cur_q;
	assign p     = valid_q[vi(paddr)] ? rd_a.pred : PRED_NONE;

	assign fin = ((state_q == S_NEXTSRC) && (s_q == n)) ||
	             ((state_q == S_ORD) && (idx_q == '0));

	assign edge_raddr = j_q[EAW-1:0];

	always_comb begin
		raddr_a = cur_q;
		raddr_b = VX_W'(edge_rd.dst);
		case (state_q)
			S_DREAD: raddr_a = VX_W'(edge_rd.src);
			S_WREAD: raddr_a = x_q;
			default: raddr_a = cur_q;
		endcase
	end

	always_comb begin
		dw = '0;
		if (state_q == S_RELAX && ok) begin
			dw = '{we: 1'b1, addr: v, pred: u, dval: sum};
		end else if (state_q == S_NEXTSRC && s_q != n && !reached_q[vi(s_q)]) begin
			dw = '{we: 1'b1, addr: s_q, pred: PRED_NONE, dval: '0};
		end
	end

	// one result per cycle in which a result is produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= fin || (state_q inside {S_OHEAD, S_OWR});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			reached_q <= '0;
			s_q       <= '0;
			round_q   <= '0;
			j_q       <= '0;
			e_q       <= '0;
			x_q       <= '0;
			walk_q    <= '0;
			cur_q     <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			last_q    <= 1'b0;
			vertex_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						s_q     <= '0;
						state_q <= S_NEXTSRC;
					end
				end
				S_NEXTSRC: begin
					if (s_q == n) begin
						found_q   <= 1'b0;
						vertex_q  <= '0;
						last_q    <= 1'b1;
						reached_q <= '0;
						state_q   <= S_IDLE;
					end else if (reached_q[vi(s_q)]) begin
						s_q <= s_q + 1'b1;
					end else begin
						valid_q <= MAX_VERTICES'(1) << vi(s_q);
						round_q <= VX_W'(1);
						j_q     <= '0;
						state_q <= S_EREAD;
					end
				end
				S_EREAD: begin
					if (j_q == total) begin
						j_q <= '0;
						if (round_q == n) begin
							reached_q <= reached_q | valid_q;
							s_q       <= s_q + 1'b1;
							state_q   <= S_NEXTSRC;
						end else begin
							round_q <= round_q + 1'b1;
						end
					end else begin
						state_q <= S_DREAD;
					end
				end
				S_DREAD: begin
					e_q     <= edge_rd;
					state_q <= S_RELAX;
				end
				S_RELAX: begin
					if (ok) begin
						valid_q[vi(v)] <= 1'b1;
					end
					if (ok && round_q == n) begin
						x_q     <= v;
						walk_q  <= '0;
						state_q <= S_WREAD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_EREAD;
					end
				end
				S_WREAD: begin
					if (walk_q == n) begin
						cur_q   <= x_q;
						cnt_q   <= '0;
						state_q <= S_CREAD;
					end else begin
						state_q <= S_WSTEP;
					end
				end
				S_WSTEP: begin
					if (p >= n) begin
						cur_q   <= x_q;
						cnt_q   <= '0;
						state_q <= S_CREAD;
					end else begin
						x_q     <= p;
						walk_q  <= walk_q + 1'b1;
						state_q <= S_WREAD;
					end
				end
				S_CREAD: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_CSTEP;
				end
				S_CSTEP: begin
					if (p >= n || p == x_q || cnt_q == n) begin
						state_q <= S_OHEAD;
					end else begin
						cur_q   <= p;
						state_q <= S_CREAD;
					end
				end
				S_OHEAD: begin
					found_q  <= 1'b1;
					vertex_q <= x_q[VTX_W-1:0];
					last_q   <= 1'b0;
					idx_q    <= cnt_q - 1'b1;
					state_q  <= S_ORD;
				end
				S_ORD: begin
					if (idx_q == '0) begin
						found_q   <= 1'b1;
						vertex_q  <= x_q[VTX_W-1:0];
						last_q    <= 1'b1;
						reached_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_OWR;
					end
				end
				S_OWR: begin
					found_q  <= 1'b1;
					vertex_q <= chain_rd_q[VTX_W-1:0];
					last_q   <= 1'b0;
					idx_q    <= idx_q - 1'b1;
					state_q  <= S_ORD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// cycle chain memory
	always_ff @(posedge clk) begin
		if (state_q == S_CREAD) begin
			chain[vi(cnt_q)] <= cur_q;
		end
		chain_rd_q <= chain[vi(idx_q)];
	end

	assign busy        = (state_q != S_IDLE);
	assign clear_edges = fin;
	assign strobe      = strobe_q;
	assign found       = found_q;
	assign vertex      = vertex_q;
	assign last        = last_q;

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> state_q == S_IDLE)
		else $error("final result while search still active");
	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !found_q |-> last_q)
		else $error("not-found result without last mark");
	a_wr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dw.we |-> (state_q == S_RELAX || state_q == S_NEXTSRC))
		else $error("distance write outside relax or init");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> reached_q == '0)
		else $error("reached marks left set while idle");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> state_q == S_IDLE)
		else $error("search end did not return to idle");

endmodule

### src/negative_cycle_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// negative_cycle_finder_top
// Loads weighted edges and runs a Bellman-Ford negative cycle search.
//
// channel   ports                                           handshake
// edge in   edge_source edge_dest edge_weight last_edge     start & !busy
// config    cfg_data                                        cfg_write
// result    cycle_found cycle_vertex last_result            result_strobe
//
// an edge without last_edge is only stored; busy stays low
// a last edge starts the search: each edge visit passes edge read, distance
// read and relax; n rounds per source run, one run per source not yet
// reached; then walk steps, collected vertices and emitted vertices follow
// the edge memory read and distance memory read-modify-write set the pace
// reset clears edge count, reached marks and sequencer; no clearing pass
// results are strobed for one cycle each; the receiver cannot stall
// ----------------------------------------------------------------------------
module negative_cycle_finder_top #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ncf_pkg::VTX_W-1:0]      edge_source,
	input  logic [ncf_pkg::VTX_W-1:0]      edge_dest,
	input  logic signed [ncf_pkg::IN_W_W-1:0] edge_weight,
	input  logic                           last_edge,
	input  logic                           cfg_write,
	input  logic [ncf_pkg::VX_W-1:0]       cfg_data,
	output logic                           result_strobe,
	output logic                           cycle_found,
	output logic [ncf_pkg::VTX_W-1:0]      cycle_vertex,
	output logic                           last_result
);
	import ncf_pkg::*;

	localparam int VIW = $clog2(MAX_VERTICES);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	logic [VX_W-1:0] vc_q, n;
	logic            accept, clear_edges;
	logic [ECW-1:0]  total;
	logic [EAW-1:0]  edge_raddr;
	edge_t           edge_rd;
	dist_wr_t        dw;
	logic [VX_W-1:0] raddr_a, raddr_b;
	dist_rd_t        rd_a, rd_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VX_W'(32);
		end else if (cfg_write) begin
			vc_q <= cfg_data;
		end
	end

	assign n      = (vc_q > VX_W'(MAX_VERTICES)) ? VX_W'(MAX_VERTICES) : vc_q;
	assign accept = start && !busy;

	ncf_edge_store #(
		.MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS), .EAW(EAW), .ECW(ECW)
	) u_store (
		.clk(clk), .arst_n(arst_n), .wr_en(accept), .wr_src(edge_source),
		.wr_dst(edge_dest), .wr_weight(edge_weight), .clear(clear_edges),
		.raddr(edge_raddr), .total(total), .rdata(edge_rd)
	);

	ncf_dist_ram #(.DEPTH(MAX_VERTICES), .AW(VIW)) u_dist (
		.clk(clk), .wr(dw), .raddr_a(raddr_a), .raddr_b(raddr_b),
		.rdata_a(rd_a), .rdata_b(rd_b)
	);

	ncf_engine #(
		.MAX_VERTICES(MAX_VERTICES), .VIW(VIW), .EAW(EAW), .ECW(ECW)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .go(accept && last_edge), .n(n), .total(total),
		.edge_raddr(edge_raddr), .edge_rd(edge_rd), .dw(dw), .raddr_a(raddr_a),
		.raddr_b(raddr_b), .rd_a(rd_a), .rd_b(rd_b), .busy(busy),
		.clear_edges(clear_edges), .strobe(result_strobe), .found(cycle_found),
		.vertex(cycle_vertex), .last(last_result)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives edge requests into the negative cycle finder. A scoreboard class
// keeps its own Bellman-Ford search, which predicts the cycle results of
// each graph. Each strobed result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	import ncf_pkg::*;

	localparam int NV       = 32;
	localparam int NE       = 256;
	localparam int WBITS    = 16;
	localparam int IDLE_MAX = 4000000;
	localparam int TAIL     = 200;
	localparam int ITEMS    = 310;

	typedef struct packed {
		logic             found;
		logic [VTX_W-1:0] vtx;
		logic             last;
	} cycle_res_t;

	class cycle_scoreboard;
		logic [VX_W-1:0]      n_cfg;
		logic [VTX_W-1:0]     e_src [NE];
		logic [VTX_W-1:0]     e_dst [NE];
		longint               e_wgt [NE];
		int                   e_cnt;
		longint               dist_v [NV];
		bit                   dvalid [NV];
		int                   pred [NV];
		bit                   reached [NV];
		cycle_res_t           pending [$];
		int                   errors;

		function new();
			n_cfg = 6'd32;
			e_cnt = 0;
			errors = 0;
			foreach (reached[i]) reached[i] = 0;
		endfunction

		function void add_res(cycle_res_t r);
			pending.insert(pending.size(), r);
		endfunction

		function bit relax_edge(int j, int n);
			int u;
			int v;
			longint s;
			u = e_src[j];
			v = e_dst[j];
			if (u >= n || v >= n || !dvalid[u]) return 0;
			s = dist_v[u] + e_wgt[j];
			if (s > 64'sd2147483647) s = 64'sd2147483647;
			if (s < -64'sd2147483648) s = -64'sd2147483648;
			if (dvalid[v] && !(s < dist_v[v])) return 0;
			dist_v[v] = s;
			dvalid[v] = 1;
			pred[v] = u;
			return 1;
		endfunction

		function bit search_from(int root, int n);
			int x;
			int cur;
			int cnt;
			int chain [NV];
			for (int i = 0; i < n; i++) begin
				dvalid[i] = 0;
				pred[i] = PRED_NONE;
				dist_v[i] = 0;
			end
			dvalid[root] = 1;
			for (int r = 1; r < n; r++)
				for (int j = 0; j < e_cnt; j++) void'(relax_edge(j, n));
			for (int j = 0; j < e_cnt; j++) begin
				if (!relax_edge(j, n)) continue;
				x = e_dst[j];
				for (int i = 0; i < n; i++) begin
					if (pred[x] >= n) break;
					x = pred[x];
				end
				cnt = 0;
				cur = x;
				do begin
					chain[cnt++] = cur;
					if (pred[cur] >= n) break;
					cur = pred[cur];
				end while (cur != x && cnt < n);
				add_res(cycle_res_t'{1'b1, x[VTX_W-1:0], 1'b0});
				for (int i = cnt; i > 1; i--)
					add_res(cycle_res_t'{1'b1, chain[i-1][VTX_W-1:0], 1'b0});
				add_res(cycle_res_t'{1'b1, x[VTX_W-1:0], 1'b1});
				return 1;
			end
			for (int i = 0; i < n; i++) if (dvalid[i]) reached[i] = 1;
			return 0;
		endfunction

		function void note_edge(logic [VTX_W-1:0] s, logic [VTX_W-1:0] d,
				logic signed [IN_W_W-1:0] w, logic lst);
			int n;
			bit hit;
			if (e_cnt < NE) begin
				e_src[e_cnt] = s;
				e_dst[e_cnt] = d;
				e_wgt[e_cnt] = longint'(w);
				e_cnt++;
			end
			if (!lst) return;
			n = (n_cfg > NV) ? NV : n_cfg;
			hit = 0;
			for (int r = 0; r < n && !hit; r++)
				if (!reached[r]) hit = search_from(r, n);
			if (!hit) add_res(cycle_res_t'{1'b0, 5'd0, 1'b1});
			e_cnt = 0;
			foreach (reached[i]) reached[i] = 0;
		endfunction

		function void check_result(cycle_res_t got);
			cycle_res_t want;
			if (pending.size() == 0) begin
				$error("unexpected result found=%0d vertex=%0d last=%0d",
					got.found, got.vtx, got.last);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.found !== want.found) begin
				$error("cycle_found expected %0d actual %0d", want.found, got.found);
				errors++;
			end
			if (got.vtx !== want.vtx) begin
				$error("cycle_vertex expected %0d actual %0d", want.vtx, got.vtx);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_result expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [VTX_W-1:0]         edge_source;
	logic [VTX_W-1:0]         edge_dest;
	logic signed [IN_W_W-1:0] edge_weight;
	logic                     last_edge;
	logic                     cfg_write;
	logic [VX_W-1:0]          cfg_data;
	logic                     result_strobe;
	logic                     cycle_found;
	logic [VTX_W-1:0]         cycle_vertex;
	logic                     last_result;

	cycle_scoreboard sb;
	int              idle_cycles = 0;
	bit              timed_out = 1'b0;
	int              edges_sent = 0;

	negative_cycle_finder_top #(
		.MAX_VERTICES(NV),
		.MAX_EDGES(NE),
		.WEIGHT_BITS(WBITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.edge_source(edge_source),
		.edge_dest(edge_dest),
		.edge_weight(edge_weight),
		.last_edge(last_edge),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.cycle_found(cycle_found),
		.cycle_vertex(cycle_vertex),
		.last_result(last_result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_strobe) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (start && !busy)
				sb.note_edge(edge_source, edge_dest, edge_weight, last_edge);
			if (result_strobe)
				sb.check_result('{cycle_found, cycle_vertex, last_result});
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_MAX && !timed_out) begin
			timed_out <= 1'b1;
			$display("CHECK FAILED");
			$finish;
		end
	end

	// called at a falling edge right after an accepted request
	task automatic idle_gap();
		int len;
		if ($urandom_range(0, 3) == 0) return;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		start <= 1'b0;
		repeat (len) @(negedge clk);
	endtask

	// entered and left at a falling edge
	task automatic send_edge(int s, int d, int w, bit lst, bit gaps);
		start <= 1'b1;
		edge_source <= s[VTX_W-1:0];
		edge_dest <= d[VTX_W-1:0];
		edge_weight <= w[IN_W_W-1:0];
		last_edge <= lst;
		while (busy) @(negedge clk);
		@(posedge clk);
		edges_sent++;
		@(negedge clk);
		if (gaps) idle_gap();
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic set_vertices(int n);
		wait_drain();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= n[VX_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.n_cfg = n[VX_W-1:0];
	endtask

	// random graph: a planted cycle with random weights plus noise edges
	task automatic random_graph(int n, int edges);
		int len;
		int v0;
		int w;
		len = $urandom_range(1, (n < 5) ? n : 5);
		v0 = $urandom_range(0, n - 1);
		for (int i = 0; i < edges; i++) begin
			if (i < len && $urandom_range(0, 3) != 0) begin
				w = $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 65535)) - 32768
					: int'($urandom_range(0, 40)) - 25;
				send_edge((v0 + i) % n, (i == len - 1) ? v0 : (v0 + i + 1) % n,
					w, i == edges - 1, 1);
			end else if ($urandom_range(0, 7) == 0) begin
				send_edge($urandom_range(0, 31), $urandom_range(0, 31),
					int'($urandom_range(0, 65535)) - 32768, i == edges - 1, 1);
			end else begin
				send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
					int'($urandom_range(0, 60)) - 10, i == edges - 1, 1);
			end
		end
	endtask

	initial begin
		int n;
		int cnt;
		sb = new();
		start = 1'b0;
		edge_source = '0;
		edge_dest = '0;
		edge_weight = '0;
		last_edge = 1'b0;
		cfg_write = 1'b0;
		cfg_data = 6'd32;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default count, extreme weights, self loop, out of range
		send_edge(0, 1, 32767, 0, 0);
		send_edge(1, 0, -32768, 0, 0);
		send_edge(31, 31, -1, 0, 0);
		send_edge(2, 2, 0, 1, 0);
		send_edge(3, 4, 5, 1, 0);
		set_vertices(1);
		send_edge(0, 0, -5, 1, 0);
		set_vertices(0);
		send_edge(0, 0, -5, 1, 0);
		set_vertices(63);
		send_edge(30, 31, -100, 0, 0);
		send_edge(31, 30, 50, 1, 0);
		set_vertices(4);
		send_edge(0, 1, 3, 0, 0);
		send_edge(2, 3, -2, 0, 0);
		send_edge(3, 2, 1, 0, 0);
		send_edge(5, 6, -9, 1, 0);
		set_vertices(2);
		send_edge(0, 1, 1, 0, 0);
		send_edge(1, 0, -1, 1, 0);
		// full edge store, last two dropped
		set_vertices(3);
		for (int i = 0; i < NE + 2; i++)
			send_edge(i % 3, (i + 1) % 3, (i == 5) ? -20 : 3, i == NE + 1, 0);

		while (edges_sent < ITEMS) begin
			case ($urandom_range(0, 5))
				0: n = 32;
				1: n = $urandom_range(1, 2);
				default: n = $urandom_range(3, 8);
			endcase
			set_vertices(n);
			cnt = $urandom_range(1, 12);
			random_graph(n, cnt);
		end

		wait_drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### sim.f
src/ncf_pkg.sv
src/ncf_edge_store.sv
src/ncf_dist_ram.sv
src/ncf_engine.sv
src/negative_cycle_finder_top.sv
tb/tb.sv
